### rtl/core/mlcb_pkg.sv
// ----------------------------------------------------------------------------
// mlcb_pkg
// Shared constants, types, the arctangent table and rounding functions of the camera basis block.
// ----------------------------------------------------------------------------
package mlcb_pkg;

    localparam int ANGLE_FRAC_BITS  = 16;
    localparam int VECTOR_FRAC_BITS = 14;
    localparam int CORDIC_STEPS     = 24;
    localparam int CORDIC_ANG_FRAC  = 22;
    localparam int CORDIC_VEC_FRAC  = 30;

    localparam int IN_W    = 16;
    localparam int SENS_W  = 16;
    localparam int VEC_W   = 16;
    localparam int YAW_W   = 25;
    localparam int PITCH_W = 24;
    localparam int OFF_W   = 17;
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SUM_W   = 40;
    localparam int CV_W    = 33;
    localparam int CZ_W    = 32;
    localparam int STEP_W  = $clog2(CORDIC_STEPS);
    localparam int RED_STEPS = 9;
    localparam int RED_W   = $clog2(RED_STEPS + 1);

    localparam int SENS_RESET = 6554;
    localparam logic [31:0] CORDIC_START = 32'd652032874;

    localparam int ASHL = (ANGLE_FRAC_BITS >= 16) ? ANGLE_FRAC_BITS - 16 : 0;
    localparam int ASHR = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
    localparam int ZSHL = CORDIC_ANG_FRAC - ANGLE_FRAC_BITS;

    localparam logic signed [SUM_W-1:0] HALF_TURN = SUM_W'(180) <<< ANGLE_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] FULL_TURN = SUM_W'(360) <<< ANGLE_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] QUARTER   = SUM_W'(90) <<< ANGLE_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] PITCH_LIM = SUM_W'(89) <<< ANGLE_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] VEC_LIM   = SUM_W'(1) <<< VECTOR_FRAC_BITS;
    localparam logic signed [PROD_W-1:0] VEC_LIM_P = PROD_W'(1) <<< VECTOR_FRAC_BITS;

    localparam int ONE_SH  = CORDIC_VEC_FRAC - VECTOR_FRAC_BITS;
    localparam int PROD_SH = 2 * CORDIC_VEC_FRAC - VECTOR_FRAC_BITS;

    typedef logic signed [CV_W-1:0] cvec_t;

    function automatic logic [CZ_W-1:0] atan_val(input logic [STEP_W-1:0] i);
        logic [CZ_W-1:0] r;
        case (i)
            5'd0:    r = 32'd188743680;
            5'd1:    r = 32'd111421900;
            5'd2:    r = 32'd58872272;
            5'd3:    r = 32'd29884485;
            5'd4:    r = 32'd15000234;
            5'd5:    r = 32'd7507429;
            5'd6:    r = 32'd3754631;
            5'd7:    r = 32'd1877430;
            5'd8:    r = 32'd938729;
            5'd9:    r = 32'd469366;
            5'd10:   r = 32'd234683;
            5'd11:   r = 32'd117342;
            5'd12:   r = 32'd58671;
            5'd13:   r = 32'd29335;
            5'd14:   r = 32'd14668;
            5'd15:   r = 32'd7334;
            5'd16:   r = 32'd3667;
            5'd17:   r = 32'd1833;
            5'd18:   r = 32'd917;
            5'd19:   r = 32'd458;
            5'd20:   r = 32'd229;
            5'd21:   r = 32'd115;
            5'd22:   r = 32'd57;
            5'd23:   r = 32'd29;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [VEC_W-1:0] round_one(input cvec_t v);
        logic signed [SUM_W-1:0] t;
        t = (SUM_W'(v) + (SUM_W'(1) <<< (ONE_SH - 1))) >>> ONE_SH;
        if (t > VEC_LIM)
            t = VEC_LIM;
        else if (t < -VEC_LIM)
            t = -VEC_LIM;
        return t[VEC_W-1:0];
    endfunction

    function automatic logic [VEC_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = (p + (PROD_W'(1) <<< (PROD_SH - 1))) >>> PROD_SH;
        if (t > VEC_LIM_P)
            t = VEC_LIM_P;
        else if (t < -VEC_LIM_P)
            t = -VEC_LIM_P;
        return t[VEC_W-1:0];
    endfunction

endpackage

### rtl/core/mlcb_in_if.sv
// ----------------------------------------------------------------------------
// mlcb_in_if
// Pointer position channel.
// ----------------------------------------------------------------------------
interface mlcb_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mlcb_pkg::IN_W-1:0]    mouse_x;
    logic signed [mlcb_pkg::IN_W-1:0]    mouse_y;

    modport source (output valid, output mouse_x, output mouse_y, input ready);
    modport sink   (input valid, input mouse_x, input mouse_y, output ready);
endinterface

### rtl/core/mlcb_out_if.sv
// ----------------------------------------------------------------------------
// mlcb_out_if
// Camera basis result channel.
// ----------------------------------------------------------------------------
interface mlcb_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mlcb_pkg::VEC_W-1:0]    front_x;
    logic signed [mlcb_pkg::VEC_W-1:0]    front_y;
    logic signed [mlcb_pkg::VEC_W-1:0]    front_z;
    logic signed [mlcb_pkg::VEC_W-1:0]    right_x;
    logic signed [mlcb_pkg::VEC_W-1:0]    right_z;
    logic signed [mlcb_pkg::VEC_W-1:0]    up_x;
    logic signed [mlcb_pkg::VEC_W-1:0]    up_y;
    logic signed [mlcb_pkg::VEC_W-1:0]    up_z;
    logic signed [mlcb_pkg::YAW_W-1:0]    yaw_now;
    logic signed [mlcb_pkg::PITCH_W-1:0]  pitch_now;

    modport source (output valid, output front_x, output front_y, output front_z,
                    output right_x, output right_z, output up_x, output up_y,
                    output up_z, output yaw_now, output pitch_now, input ready);
    modport sink   (input valid, input front_x, input front_y, input front_z,
                    input right_x, input right_z, input up_x, input up_y,
                    input up_z, input yaw_now, input pitch_now, output ready);
endinterface

### rtl/core/mlcb_smul.sv
// ----------------------------------------------------------------------------
// mlcb_smul
// Bit-serial signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module mlcb_smul
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      start,
    input  logic signed [mlcb_pkg::MUL_W-1:0]         a,
    input  logic signed [mlcb_pkg::MUL_W-1:0]         b,
    output logic                                      done,
    output logic signed [mlcb_pkg::PROD_W-1:0]        p
);

    localparam int CNT_W = $clog2(mlcb_pkg::MUL_W);

    logic signed [mlcb_pkg::PROD_W-1:0] a_reg;
    logic        [mlcb_pkg::MUL_W-1:0]  b_reg;
    logic signed [mlcb_pkg::PROD_W-1:0] acc_reg;
    logic        [CNT_W-1:0]            cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic signed [mlcb_pkg::PROD_W-1:0] acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (b_reg[0])
        begin
            if (cnt_reg == CNT_W'(mlcb_pkg::MUL_W - 1))
                acc_next = acc_reg - a_reg;
            else
                acc_next = acc_reg + a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(mlcb_pkg::MUL_W - 1));
            if (start)
            begin
                a_reg    <= mlcb_pkg::PROD_W'(a);
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                a_reg   <= a_reg <<< 1;
                b_reg   <= b_reg >> 1;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(mlcb_pkg::MUL_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

### rtl/core/mlcb_cordic.sv
// ----------------------------------------------------------------------------
// mlcb_cordic
// Iterative sine and cosine in degrees, one rotation step per cycle.
// ----------------------------------------------------------------------------
module mlcb_cordic
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [mlcb_pkg::YAW_W-1:0]     angle,
    output logic                                  done,
    output mlcb_pkg::cvec_t                       sin_out,
    output mlcb_pkg::cvec_t                       cos_out
);

    mlcb_pkg::cvec_t                     x_reg;
    mlcb_pkg::cvec_t                     y_reg;
    logic signed [mlcb_pkg::CZ_W-1:0]    z_reg;
    logic        [mlcb_pkg::STEP_W-1:0]  i_reg;
    logic                                flip_reg;
    logic                                busy_reg;
    logic                                done_reg;
    logic signed [mlcb_pkg::SUM_W-1:0]   ang_w;
    logic signed [mlcb_pkg::SUM_W-1:0]   ang_f;
    logic                                flip_f;
    mlcb_pkg::cvec_t                     xs;
    mlcb_pkg::cvec_t                     ys;
    logic signed [mlcb_pkg::CZ_W-1:0]    at;

    always_comb
    begin
        ang_w  = mlcb_pkg::SUM_W'(angle);
        ang_f  = ang_w;
        flip_f = 1'b0;
        if (ang_w > mlcb_pkg::QUARTER)
        begin
            ang_f  = ang_w - mlcb_pkg::HALF_TURN;
            flip_f = 1'b1;
        end
        else if (ang_w < -mlcb_pkg::QUARTER)
        begin
            ang_f  = ang_w + mlcb_pkg::HALF_TURN;
            flip_f = 1'b1;
        end
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        at = mlcb_pkg::atan_val(i_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start
                        && (i_reg == mlcb_pkg::STEP_W'(mlcb_pkg::CORDIC_STEPS - 1));
            if (start)
            begin
                x_reg    <= mlcb_pkg::CV_W'(mlcb_pkg::CORDIC_START);
                y_reg    <= '0;
                z_reg    <= mlcb_pkg::CZ_W'(ang_f <<< mlcb_pkg::ZSHL);
                flip_reg <= flip_f;
                i_reg    <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + at;
                end
                i_reg <= i_reg + 1'b1;
                if (i_reg == mlcb_pkg::STEP_W'(mlcb_pkg::CORDIC_STEPS - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done    = done_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;

endmodule

### rtl/core/mouse_look_camera_basis.sv
// ----------------------------------------------------------------------------
// mouse_look_camera_basis
// Yaw and pitch camera driven by pointer motion; outputs front, right, up.
// ----------------------------------------------------------------------------
// in_ch carries one pointer position per transaction; out_ch returns one
// result transaction per input: the front, right and up vectors in Q1.14
// and the new yaw and pitch. The APB port holds the sensitivity register.
// The first transaction after reset latches the position and applies zero motion.
// Each result takes two bit-serial multiplies for the motion, a modulo
// reduction of yaw, two passes through the shared CORDIC unit and four
// serial products, then a load of the output register.
// One item is in flight at a time; in_ch is ready whenever the sequencer
// is idle, also while a result waits.
// When out_ch stalls, the finished result holds in the output register and
// a next result waits in the sequencer until it frees.
// Reset clears angles, last position and the output valid, and sets
// sensitivity to 6554.
// ----------------------------------------------------------------------------
module mouse_look_camera_basis
(
    input  logic        clk,
    input  logic        rst_n,
    mlcb_in_if.sink     in_ch,
    mlcb_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {ST_IDLE, ST_MULX, ST_MULY, ST_RED, ST_CORY, ST_CORP,
                              ST_PROD, ST_DONE} state_t;

    localparam int VW = mlcb_pkg::VEC_W;
    localparam int SW = mlcb_pkg::SUM_W;
    localparam logic [2:0] ADDR_SENS = 3'd0;

    state_t                                 state_reg;
    logic [mlcb_pkg::SENS_W-1:0]            sens_reg;
    logic                                   first_reg;
    logic signed [mlcb_pkg::IN_W-1:0]       last_x_reg;
    logic signed [mlcb_pkg::IN_W-1:0]       last_y_reg;
    logic signed [mlcb_pkg::OFF_W-1:0]      off_x_reg;
    logic signed [mlcb_pkg::OFF_W-1:0]      off_y_reg;
    logic signed [SW-1:0]                   dx_reg;
    logic signed [SW-1:0]                   s_reg;
    logic [mlcb_pkg::RED_W-1:0]             k_reg;
    logic signed [mlcb_pkg::YAW_W-1:0]      yaw_reg;
    logic signed [mlcb_pkg::PITCH_W-1:0]    pitch_reg;
    mlcb_pkg::cvec_t                        sy_reg;
    mlcb_pkg::cvec_t                        cy_reg;
    mlcb_pkg::cvec_t                        sp_reg;
    mlcb_pkg::cvec_t                        cp_reg;
    logic [1:0]                             pidx_reg;
    logic [VW-1:0]                          prod_reg [4];
    logic                                   go_reg;
    logic                                   go_next;
    logic                                   ovalid_reg;
    logic                                   out_load;
    logic [VW-1:0]                          o_fx_reg;
    logic [VW-1:0]                          o_fy_reg;
    logic [VW-1:0]                          o_fz_reg;
    logic [VW-1:0]                          o_rx_reg;
    logic [VW-1:0]                          o_rz_reg;
    logic [VW-1:0]                          o_ux_reg;
    logic [VW-1:0]                          o_uy_reg;
    logic [VW-1:0]                          o_uz_reg;
    logic [mlcb_pkg::YAW_W-1:0]             o_yaw_reg;
    logic [mlcb_pkg::PITCH_W-1:0]           o_pitch_reg;

    logic                                   mul_start;
    logic signed [mlcb_pkg::MUL_W-1:0]      mul_a;
    logic signed [mlcb_pkg::MUL_W-1:0]      mul_b;
    logic                                   mul_done;
    logic signed [mlcb_pkg::PROD_W-1:0]     mul_p;
    logic                                   cor_start;
    logic signed [mlcb_pkg::YAW_W-1:0]      cor_ang;
    logic                                   cor_done;
    mlcb_pkg::cvec_t                        cor_s;
    mlcb_pkg::cvec_t                        cor_c;

    logic signed [mlcb_pkg::PROD_W-1:0]     d_scaled;
    logic signed [SW-1:0]                   d_w;
    logic signed [SW-1:0]                   yaw_sum;
    logic signed [SW-1:0]                   pitch_sum;
    logic signed [SW-1:0]                   red_mod;
    logic signed [SW-1:0]                   s_sub;
    logic                                   in_acc;
    logic signed [mlcb_pkg::OFF_W-1:0]      in_x_w;
    logic signed [mlcb_pkg::OFF_W-1:0]      in_y_w;

    mlcb_smul u_smul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .p     (mul_p)
    );

    mlcb_cordic u_cordic
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_ang),
        .done    (cor_done),
        .sin_out (cor_s),
        .cos_out (cor_c)
    );

    always_comb
    begin
        in_acc    = in_ch.valid && (state_reg == ST_IDLE);
        in_x_w    = mlcb_pkg::OFF_W'(in_ch.mouse_x);
        in_y_w    = mlcb_pkg::OFF_W'(in_ch.mouse_y);
        mul_start = go_reg && ((state_reg == ST_MULX) || (state_reg == ST_MULY)
                               || (state_reg == ST_PROD));
        cor_start = go_reg && ((state_reg == ST_CORY) || (state_reg == ST_CORP));
        cor_ang   = (state_reg == ST_CORP) ? mlcb_pkg::YAW_W'(pitch_reg) : yaw_reg;
        go_next   = in_acc
                    || ((state_reg == ST_MULX) && mul_done)
                    || ((state_reg == ST_RED) && (k_reg == '0))
                    || (((state_reg == ST_CORY) || (state_reg == ST_CORP)) && cor_done)
                    || ((state_reg == ST_PROD) && mul_done && (pidx_reg != 2'd3));
        out_load  = (state_reg == ST_DONE) && (!ovalid_reg || out_ch.ready);
        mul_a     = '0;
        mul_b     = '0;
        case (state_reg)
            ST_MULX:
            begin
                mul_a = mlcb_pkg::MUL_W'(off_x_reg);
                mul_b = mlcb_pkg::MUL_W'(sens_reg);
            end
            ST_MULY:
            begin
                mul_a = mlcb_pkg::MUL_W'(off_y_reg);
                mul_b = mlcb_pkg::MUL_W'(sens_reg);
            end
            ST_PROD:
            begin
                case (pidx_reg)
                    2'd0:
                    begin
                        mul_a = mlcb_pkg::MUL_W'(cy_reg);
                        mul_b = mlcb_pkg::MUL_W'(cp_reg);
                    end
                    2'd1:
                    begin
                        mul_a = mlcb_pkg::MUL_W'(sy_reg);
                        mul_b = mlcb_pkg::MUL_W'(cp_reg);
                    end
                    2'd2:
                    begin
                        mul_a = mlcb_pkg::MUL_W'(-cy_reg);
                        mul_b = mlcb_pkg::MUL_W'(sp_reg);
                    end
                    default:
                    begin
                        mul_a = mlcb_pkg::MUL_W'(-sy_reg);
                        mul_b = mlcb_pkg::MUL_W'(sp_reg);
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        d_scaled  = (mul_p <<< mlcb_pkg::ASHL) >>> mlcb_pkg::ASHR;
        d_w       = SW'(d_scaled);
        yaw_sum   = SW'(yaw_reg) + dx_reg + mlcb_pkg::HALF_TURN;
        red_mod   = mlcb_pkg::FULL_TURN <<< k_reg;
        s_sub     = (s_reg >= red_mod) ? s_reg - red_mod : s_reg;
        pitch_sum = SW'(pitch_reg) + d_w;
        if (pitch_sum > mlcb_pkg::PITCH_LIM)
            pitch_sum = mlcb_pkg::PITCH_LIM;
        else if (pitch_sum < -mlcb_pkg::PITCH_LIM)
            pitch_sum = -mlcb_pkg::PITCH_LIM;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            first_reg  <= 1'b1;
            last_x_reg <= '0;
            last_y_reg <= '0;
            yaw_reg    <= '0;
            pitch_reg  <= '0;
            go_reg     <= 1'b0;
            ovalid_reg <= 1'b0;
            pidx_reg   <= '0;
            k_reg      <= '0;
        end
        else
        begin
            go_reg <= go_next;
            if (out_load)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && out_ch.ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        if (first_reg)
                        begin
                            off_x_reg <= '0;
                            off_y_reg <= '0;
                        end
                        else
                        begin
                            off_x_reg <= in_x_w - mlcb_pkg::OFF_W'(last_x_reg);
                            off_y_reg <= mlcb_pkg::OFF_W'(last_y_reg) - in_y_w;
                        end
                        last_x_reg <= in_ch.mouse_x;
                        last_y_reg <= in_ch.mouse_y;
                        first_reg  <= 1'b0;
                        state_reg  <= ST_MULX;
                    end
                end
                ST_MULX:
                begin
                    if (mul_done)
                    begin
                        dx_reg    <= d_w;
                        state_reg <= ST_MULY;
                    end
                end
                ST_MULY:
                begin
                    if (mul_done)
                    begin
                        if (yaw_sum < 0)
                            s_reg <= yaw_sum + (mlcb_pkg::FULL_TURN <<< mlcb_pkg::RED_STEPS);
                        else
                            s_reg <= yaw_sum;
                        pitch_reg <= mlcb_pkg::PITCH_W'(pitch_sum);
                        k_reg     <= mlcb_pkg::RED_W'(mlcb_pkg::RED_STEPS);
                        state_reg <= ST_RED;
                    end
                end
                ST_RED:
                begin
                    s_reg <= s_sub;
                    if (k_reg == '0)
                    begin
                        yaw_reg   <= mlcb_pkg::YAW_W'(s_sub - mlcb_pkg::HALF_TURN);
                        state_reg <= ST_CORY;
                    end
                    else
                        k_reg <= k_reg - 1'b1;
                end
                ST_CORY:
                begin
                    if (cor_done)
                    begin
                        sy_reg    <= cor_s;
                        cy_reg    <= cor_c;
                        state_reg <= ST_CORP;
                    end
                end
                ST_CORP:
                begin
                    if (cor_done)
                    begin
                        sp_reg    <= cor_s;
                        cp_reg    <= cor_c;
                        pidx_reg  <= '0;
                        state_reg <= ST_PROD;
                    end
                end
                ST_PROD:
                begin
                    if (mul_done)
                    begin
                        prod_reg[pidx_reg] <= mlcb_pkg::round_prod(mul_p);
                        if (pidx_reg == 2'd3)
                            state_reg <= ST_DONE;
                        else
                            pidx_reg <= pidx_reg + 1'b1;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        o_fx_reg    <= prod_reg[0];
                        o_fy_reg    <= mlcb_pkg::round_one(sp_reg);
                        o_fz_reg    <= prod_reg[1];
                        o_rx_reg    <= mlcb_pkg::round_one(-sy_reg);
                        o_rz_reg    <= mlcb_pkg::round_one(cy_reg);
                        o_ux_reg    <= prod_reg[2];
                        o_uy_reg    <= mlcb_pkg::round_one(cp_reg);
                        o_uz_reg    <= prod_reg[3];
                        o_yaw_reg   <= yaw_reg;
                        o_pitch_reg <= pitch_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sens_reg <= mlcb_pkg::SENS_W'(mlcb_pkg::SENS_RESET);
        else if (psel && penable && pwrite && (paddr == ADDR_SENS))
            sens_reg <= pwdata[mlcb_pkg::SENS_W-1:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SENS) ? {{(32 - mlcb_pkg::SENS_W){1'b0}}, sens_reg} : '0;

    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign out_ch.valid     = ovalid_reg;
    assign out_ch.front_x   = o_fx_reg;
    assign out_ch.front_y   = o_fy_reg;
    assign out_ch.front_z   = o_fz_reg;
    assign out_ch.right_x   = o_rx_reg;
    assign out_ch.right_z   = o_rz_reg;
    assign out_ch.up_x      = o_ux_reg;
    assign out_ch.up_y      = o_uy_reg;
    assign out_ch.up_z      = o_uz_reg;
    assign out_ch.yaw_now   = o_yaw_reg;
    assign out_ch.pitch_now = o_pitch_reg;

endmodule

### rtl/core/mlcb_checker.sv
// ----------------------------------------------------------------------------
// mlcb_checker
// Port-level checks of the camera basis block, bound to the top level.
// ----------------------------------------------------------------------------
module mlcb_checker
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_ready,
    input  logic                                  out_valid,
    input  logic                                  out_ready,
    input  logic signed [mlcb_pkg::VEC_W-1:0]     right_x,
    input  logic signed [mlcb_pkg::VEC_W-1:0]     up_y,
    input  logic signed [mlcb_pkg::PITCH_W-1:0]   pitch_now
);

    localparam logic signed [mlcb_pkg::PITCH_W-1:0] PLIM =
        mlcb_pkg::PITCH_W'(mlcb_pkg::PITCH_LIM);
    localparam logic signed [mlcb_pkg::VEC_W-1:0] VLIM =
        mlcb_pkg::VEC_W'(mlcb_pkg::VEC_LIM);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pitch_now) && $stable(right_x))
        else $error("result changed while stalled");

    // no input taken while a transaction is in progress
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted twice in a row");

    // pitch stays inside the limit
    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_now <= PLIM) && (pitch_now >= -PLIM))
        else $error("pitch out of range");

    // up y is cos(pitch), never negative
    a_upy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (up_y >= 0) && (up_y <= VLIM))
        else $error("up y out of range");

endmodule

bind mouse_look_camera_basis mlcb_checker u_mlcb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .right_x   (out_ch.right_x),
    .up_y      (out_ch.up_y),
    .pitch_now (out_ch.pitch_now)
);
